// ===== hdl/sfrg_pkg.sv =====
// ----------------------------------------------------------------------------
// sfrg_pkg
// Types, constants and round functions of the SHA-256 random generator.
// ----------------------------------------------------------------------------
package sfrg_pkg;

   localparam int DigestBytes = 32;

   typedef logic [31:0] word_type;

   localparam logic [255:0] Iv = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic CMD_GENERATE    = 1'b0;
   localparam logic CMD_LOAD        = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_UNSEEDED = 1'b1;

   function automatic word_type round_const(input logic [5:0] t);
      word_type k;
      unique case (t)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type ror(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [63:0] bswap64(input logic [63:0] x);
      logic [63:0] y;
      for (int i = 0; i < 8; i++) y[8*i +: 8] = x[56-8*i +: 8];
      return y;
   endfunction

endpackage

// ===== hdl/sha256_feedback_random_generator.sv =====
// ----------------------------------------------------------------------------
// sha256_feedback_random_generator
// Counter-mode SHA-256 random generator with digest feedback into the pool.
// ----------------------------------------------------------------------------
// A load is written into the pool while idle. A generate runs one SHA-256
// round per cycle on a single shared round unit: 64 rounds plus a digest
// add per compression, one compression without hardware random input and
// two with it; then up to four output words follow, each held until
// rsp_ready, and the sequencer returns to idle before the next request is
// taken. An unseeded generate answers in the cycle after acceptance with
// status set. req_ready is high only while the sequencer idles.
module sha256_feedback_random_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [63:0] req_hw_random,
   input  logic        req_hw_random_present,
   input  logic [63:0] req_timestamp,
   input  logic [5:0]  req_byte_count,
   input  logic [1:0]  req_pool_index,
   input  logic [63:0] req_pool_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_random_word,
   output logic [3:0]  rsp_valid_bytes,
   output logic        rsp_last,
   output logic        rsp_status
);
   import sfrg_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_OUT   = 3'd3;
   localparam logic [2:0] ST_ERR   = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [255:0]   pool_ff, pool_in;
   logic [63:0]    ctr_ff, ctr_in;
   logic           seeded_ff, seeded_in;
   logic [255:0]   h_ff, h_in;
   logic [255:0]   v_ff, v_in;
   logic [511:0]   w_ff, w_in;
   logic [511:0]   blk2_ff, blk2_in;
   logic           two_ff, two_in;
   logic           second_ff, second_in;
   logic [5:0]     rnd_ff, rnd_in;
   logic [5:0]     left_ff, left_in;
   logic [1:0]     widx_ff, widx_in;

   logic [1023:0]  msg;
   word_type       a, b, c, d, e, f, g, hh, wt, t1, t2, s0, s1, wnew;
   logic [63:0]    out_word;
   logic [63:0]    ctr_next;
   logic [5:0]     cnt_sat;

   assign ctr_next = ctr_ff + 64'd1;
   assign cnt_sat  = (req_byte_count > 6'(DigestBytes)) ? 6'(DigestBytes) : req_byte_count;

   // message: optional hw, pool, counter, timestamp, padding, bit length
   always_comb begin
      msg = '0;
      if (req_hw_random_present) begin
         msg[1023 -: 64]  = bswap64(req_hw_random);
         msg[959 -: 256]  = pool_ff;
         msg[703 -: 64]   = bswap64(ctr_next);
         msg[639 -: 64]   = bswap64(req_timestamp);
         msg[575 -: 8]    = 8'h80;
         msg[15:0]        = 16'd448;
      end else begin
         msg[1023 -: 256] = pool_ff;
         msg[767 -: 64]   = bswap64(ctr_next);
         msg[703 -: 64]   = bswap64(req_timestamp);
         msg[639 -: 8]    = 8'h80;
         msg[527:512]     = 16'd384;
      end
   end

   always_comb begin
      {a, b, c, d, e, f, g, hh} = v_ff;
      wt   = w_ff[511 -: 32];
      s0   = ror(w_ff[479 -: 32], 7) ^ ror(w_ff[479 -: 32], 18) ^ (w_ff[479 -: 32] >> 3);
      s1   = ror(w_ff[63 -: 32], 17) ^ ror(w_ff[63 -: 32], 19) ^ (w_ff[63 -: 32] >> 10);
      wnew = wt + s0 + w_ff[223 -: 32] + s1;
      t1   = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
             + round_const(rnd_ff) + wt;
      t2   = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
   end

   always_comb begin
      out_word = h_ff[255 - 64*widx_ff -: 64];
      if (left_ff < 6'd8)
         out_word = out_word & ~(64'hffffffffffffffff >> (8 * left_ff));
   end

   always_comb begin
      state_in  = state_ff;
      pool_in   = pool_ff;
      ctr_in    = ctr_ff;
      seeded_in = seeded_ff;
      h_in      = h_ff;
      v_in      = v_ff;
      w_in      = w_ff;
      blk2_in   = blk2_ff;
      two_in    = two_ff;
      second_in = second_ff;
      rnd_in    = rnd_ff;
      left_in   = left_ff;
      widx_in   = widx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_LOAD) begin
                  pool_in[255 - 64*req_pool_index -: 64] = req_pool_value;
                  if (req_pool_index == 2'd3) begin
                     ctr_in    = 64'd1;
                     seeded_in = 1'b1;
                  end
               end else if (req_byte_count != 6'd0) begin
                  if (!seeded_ff) begin
                     state_in = ST_ERR;
                  end else begin
                     ctr_in    = ctr_next;
                     h_in      = Iv;
                     v_in      = Iv;
                     w_in      = msg[1023 -: 512];
                     blk2_in   = msg[511:0];
                     two_in    = req_hw_random_present;
                     second_in = 1'b0;
                     rnd_in    = 6'd0;
                     left_in   = cnt_sat;
                     widx_in   = 2'd0;
                     state_in  = ST_ROUND;
                  end
               end
            end
         end
         ST_ROUND: begin
            v_in   = {t1 + t2, a, b, c, d + t1, e, f, g};
            w_in   = {w_ff[479:0], wnew};
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_ADD;
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++)
               h_in[32*i +: 32] = h_ff[32*i +: 32] + v_ff[32*i +: 32];
            if (two_ff && !second_ff) begin
               second_in = 1'b1;
               v_in      = h_in;
               w_in      = blk2_ff;
               state_in  = ST_ROUND;
            end else begin
               pool_in  = pool_ff ^ h_in;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               widx_in = widx_ff + 2'd1;
               if (left_ff <= 6'd8) state_in = ST_IDLE;
               else left_in = left_ff - 6'd8;
            end
         end
         ST_ERR: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pool_ff   <= '0;
         ctr_ff    <= '0;
         seeded_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pool_ff   <= pool_in;
         ctr_ff    <= ctr_in;
         seeded_ff <= seeded_in;
      end
      h_ff      <= h_in;
      v_ff      <= v_in;
      w_ff      <= w_in;
      blk2_ff   <= blk2_in;
      two_ff    <= two_in;
      second_ff <= second_in;
      rnd_ff    <= rnd_in;
      left_ff   <= left_in;
      widx_ff   <= widx_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT) || (state_ff == ST_ERR);
   assign rsp_random_word = (state_ff == ST_OUT) ? out_word : 64'd0;
   assign rsp_valid_bytes = (state_ff != ST_OUT) ? 4'd0
                            : (left_ff >= 6'd8) ? 4'd8 : left_ff[3:0];
   assign rsp_last        = (state_ff == ST_ERR) || (left_ff <= 6'd8);
   assign rsp_status      = (state_ff == ST_ERR) ? STATUS_UNSEEDED : STATUS_OK;

   a_err_needs_unseeded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && state_in == ST_ERR) |-> !seeded_ff)
      else $error("error response while seeded");
   a_round_wraps_to_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == 6'd63) |=> state_ff == ST_ADD)
      else $error("round counter did not end compression");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_random_word))
      else $error("response changed while stalled");
endmodule
